/* rtl/clut_pkg.sv */
// Shared types, codes and constants for the palette texel decoder.
// Depends on nothing; the files that use it refer to it by scoped names.
package clut_pkg;

	// Default palette depth in entries.
	localparam int PALETTE_DEPTH = 256;

	// Item opcodes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_TEXEL = 1'b1;

	// Blend modes applied to semi-transparent texels.
	localparam logic [1:0] BLEND_HALF    = 2'd0;
	localparam logic [1:0] BLEND_FULL    = 2'd1;
	localparam logic [1:0] BLEND_INV     = 2'd2;
	localparam logic [1:0] BLEND_QUARTER = 2'd3;

	// 5-5-5 color word layout.
	localparam logic [15:0] RED_MASK   = 16'b00000000_00011111;
	localparam logic [15:0] GREEN_MASK = 16'b00000011_11100000;
	localparam logic [15:0] BLUE_MASK  = 16'b01111100_00000000;
	localparam logic [15:0] SEMI_MASK  = 16'b10000000_00000000;
	localparam int          GREEN_LSB  = 5;
	localparam int          BLUE_LSB   = 10;

	localparam logic [3:0] NIBBLE_MASK  = 4'hF;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_HALF   = 8'd127;

	// Unpacked pixel handed from the unpack stage to the alpha stage.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] max_ch;    // largest of the three expanded channels
		logic       zero_word; // palette word was all zeros
		logic       blend_on;  // semi bit set on a transparent face
	} clut_pix_t;

endpackage

/* rtl/clut_palette.sv */
// Palette memory: one write port, one read port, registered read data.
// Depends on no package; depth and address width come from the top level.
module clut_palette #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [15:0]       wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [15:0]       rd_data
);

	logic [15:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/clut_unpack.sv */
// Unpack a 5-5-5 palette word into expanded channels, their maximum and flags.
// Depends on clut_pkg for the word layout and the pixel struct.
module clut_unpack (
	input  logic                  [15:0] word,
	input  logic                         face_transparent,
	output clut_pkg::clut_pix_t          pix
);

	logic [4:0] red5;
	logic [4:0] green5;
	logic [4:0] blue5;
	logic [7:0] red8;
	logic [7:0] green8;
	logic [7:0] blue8;
	logic [7:0] max_rg;

	always_comb begin
		red5   = 5'(word & clut_pkg::RED_MASK);
		green5 = 5'((word & clut_pkg::GREEN_MASK) >> clut_pkg::GREEN_LSB);
		blue5  = 5'((word & clut_pkg::BLUE_MASK) >> clut_pkg::BLUE_LSB);
		red8   = {red5, 3'b000};
		green8 = {green5, 3'b000};
		blue8  = {blue5, 3'b000};
		max_rg = (red8 > green8) ? red8 : green8;

		pix.red       = red8;
		pix.green     = green8;
		pix.blue      = blue8;
		pix.max_ch    = (max_rg > blue8) ? max_rg : blue8;
		pix.zero_word = (word == 16'd0);
		pix.blend_on  = ((word & clut_pkg::SEMI_MASK) != 16'd0) && face_transparent;
	end

endmodule

/* rtl/clut_alpha.sv */
// Alpha selection from the blend mode, the channel maximum and its square.
// Depends on clut_pkg for blend codes, alpha constants and the pixel struct.
module clut_alpha (
	input  clut_pkg::clut_pix_t       pix,
	input  logic                [7:0] max_sq,  // (max * max) >> 8
	input  logic                [1:0] blend_mode,
	output logic                [7:0] alpha
);

	logic [7:0] sq_x4;

	always_comb begin
		// saturate (max_sq * 4) to 255
		sq_x4 = (max_sq[7:6] != 2'b00) ? 8'hFF : {max_sq[5:0], 2'b00};

		if (pix.zero_word) begin
			alpha = 8'd0;
		end else if (!pix.blend_on) begin
			alpha = clut_pkg::ALPHA_OPAQUE;
		end else begin
			case (blend_mode)
				clut_pkg::BLEND_HALF:    alpha = clut_pkg::ALPHA_HALF;
				clut_pkg::BLEND_FULL:    alpha = sq_x4;
				clut_pkg::BLEND_INV:     alpha = clut_pkg::ALPHA_OPAQUE - pix.max_ch;
				clut_pkg::BLEND_QUARTER: alpha = max_sq;
				default:                 alpha = clut_pkg::ALPHA_OPAQUE;
			endcase
		end
	end

endmodule

/* rtl/clut_texel_to_rgba.sv */
// Top level of the palette texel decoder: input stage, palette, unpack, square, alpha.
// Depends on clut_pkg, clut_palette, clut_unpack and clut_alpha.
//
// Palette texel decoder. A load item (opcode OP_LOAD) writes palette_word into
// palette entry palette_slot and gives no result; slots at or beyond
// PALETTE_DEPTH are ignored. A texel item (OP_TEXEL) forms an index from
// texel_byte (low or high nibble in 4-bit mode, chosen by odd_column), reads
// the palette and returns one RGBA result: each 5-bit channel shifted left by
// three, alpha from the semi bit, the face flag and the blend mode. A zero
// word, or an index at or beyond PALETTE_DEPTH, gives all zeros. Reading an
// entry that was never written returns whatever the memory holds. The block
// is a five-stage pipeline: input register, palette read, unpack and channel
// maximum, 8x8 square, alpha select into the output register. One item is
// accepted every cycle while the output is not stalled. The whole pipeline
// advances together whenever the output register is empty or being taken,
// so in_ready follows out_ready; empty slots left by load items travel along
// as bubbles. Loads and reads share the palette stage, so a texel always
// sees every load accepted before it.
module clut_texel_to_rgba #(
	parameter int PALETTE_DEPTH = clut_pkg::PALETTE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [7:0] palette_slot,
	input  logic [15:0] palette_word,
	input  logic [7:0] texel_byte,
	input  logic       odd_column,
	input  logic       four_bit_mode,
	input  logic       face_transparent,
	input  logic [1:0] blend_mode,

	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] alpha
);

	localparam int ADDR_W = $clog2(PALETTE_DEPTH);

	// Advance every stage at once; hold everything while the result waits.
	logic adv;

	// Stage 1: registered input item with its palette index.
	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  slot_s1;
	logic [15:0] word_s1;
	logic [7:0]  idx_s1;
	logic        trans_s1;
	logic [1:0]  mode_s1;

	// Stage 2: palette read data (inside the memory) and texel attributes.
	logic        valid_s2;
	logic        idx_ok_s2;
	logic        trans_s2;
	logic [1:0]  mode_s2;

	// Stage 3: unpacked pixel.
	logic                valid_s3;
	clut_pkg::clut_pix_t pix_s3;
	logic [1:0]          mode_s3;

	// Stage 4: squared maximum.
	logic                valid_s4;
	clut_pkg::clut_pix_t pix_s4;
	logic [1:0]          mode_s4;
	logic [7:0]          sq_s4;

	logic        out_valid_q;
	logic [3:0]  nibble;
	logic [7:0]  idx_in;
	logic        slot_ok;
	logic        idx_ok;
	logic        pal_wr;
	logic        pal_rd;
	logic [15:0] pal_data;
	logic [15:0] word_eff;
	logic [15:0] max_prod;
	logic [7:0]  alpha_c;
	clut_pkg::clut_pix_t pix_c;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;

	// Pick the palette index: a nibble in 4-bit mode, the whole byte otherwise.
	always_comb begin
		nibble = odd_column ? (texel_byte[7:4] & clut_pkg::NIBBLE_MASK)
		                    : (texel_byte[3:0] & clut_pkg::NIBBLE_MASK);
		idx_in = four_bit_mode ? {4'b0000, nibble} : texel_byte;
	end

	// Valid bits: cleared by reset, advanced with the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= in_valid;
			// drop load items here: they end at the palette write
			valid_s2    <= valid_s1 && (op_s1 == clut_pkg::OP_TEXEL);
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1    <= opcode;
			slot_s1  <= palette_slot;
			word_s1  <= palette_word;
			idx_s1   <= idx_in;
			trans_s1 <= face_transparent;
			mode_s1  <= blend_mode;

			idx_ok_s2 <= idx_ok;
			trans_s2  <= trans_s1;
			mode_s2   <= mode_s1;

			pix_s3  <= pix_c;
			mode_s3 <= mode_s2;

			pix_s4  <= pix_s3;
			mode_s4 <= mode_s3;
			sq_s4   <= max_prod[15:8];

			red   <= pix_s4.red;
			green <= pix_s4.green;
			blue  <= pix_s4.blue;
			alpha <= alpha_c;
		end
	end

	// Palette stage: loads write, texels read, both in item order.
	assign slot_ok = {1'b0, slot_s1} < 9'(PALETTE_DEPTH);
	assign idx_ok  = {1'b0, idx_s1} < 9'(PALETTE_DEPTH);
	assign pal_wr  = adv && valid_s1 && (op_s1 == clut_pkg::OP_LOAD) && slot_ok;
	assign pal_rd  = adv && valid_s1 && (op_s1 == clut_pkg::OP_TEXEL);

	clut_palette #(
		.DEPTH  (PALETTE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_palette (
		.clk     (clk),
		.wr_en   (pal_wr),
		.wr_addr (slot_s1[ADDR_W-1:0]),
		.wr_data (word_s1),
		.rd_en   (pal_rd),
		.rd_addr (idx_s1[ADDR_W-1:0]),
		.rd_data (pal_data)
	);

	// An index beyond the palette reads as a zero word.
	assign word_eff = idx_ok_s2 ? pal_data : 16'd0;

	clut_unpack u_unpack (
		.word             (word_eff),
		.face_transparent (trans_s2),
		.pix              (pix_c)
	);

	// Square the channel maximum; keep the upper byte.
	assign max_prod = 16'(pix_s3.max_ch) * 16'(pix_s3.max_ch);

	clut_alpha u_alpha (
		.pix        (pix_s4),
		.max_sq     (sq_s4),
		.blend_mode (mode_s4),
		.alpha      (alpha_c)
	);

endmodule

/* rtl/clut_checker.sv */
// Port-level checks for the palette texel decoder, bound to the top level.
// Depends on clut_texel_to_rgba's port names; no package needed.
module clut_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic [7:0] alpha
);

	// Hold a stalled result item.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(alpha))
		else $error("result item changed while stalled");

	// Expanded channels always have their low three bits clear.
	a_chan_lsb: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red[2:0] == 3'b000) && (green[2:0] == 3'b000)
			&& (blue[2:0] == 3'b000))
		else $error("channel low bits not clear");

	// Black texels can only carry zero, half or opaque alpha.
	a_black_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (red == 8'd0) && (green == 8'd0) && (blue == 8'd0)
			|-> (alpha == 8'd0) || (alpha == 8'd127) || (alpha == 8'd255))
		else $error("unexpected alpha on black texel");

	// A result appears only after the pipeline advanced.
	a_rise_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared while the pipeline was held");

endmodule

bind clut_texel_to_rgba clut_checker u_checker (.*);

/* verif/tb_clut_texel_to_rgba.sv */
// Self-checking testbench for the palette texel decoder clut_texel_to_rgba.
// Depends on clut_pkg and the RTL; a scoreboard class predicts each RGBA result
// from its own palette copy while plain tasks drive loads and texels.
module tb_clut_texel_to_rgba;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CALM_ITEMS   = 150;   // tail of the run without idling
	localparam int HOLD_AT      = 300;   // items sent before the long output stall
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 20;    // five-stage pipeline, with margin
	localparam int CYCLE_LIMIT  = 200000;

	// One input item, all fields as driven on the ports.
	typedef struct {
		logic        op;
		logic [7:0]  slot;
		logic [15:0] word;
		logic [7:0]  tbyte;
		logic        odd;
		logic        four;
		logic        transp;
		logic [1:0]  mode;
	} texel_req_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	// Palette shadow plus queue of pixels still owed by the block.
	class rgba_scoreboard;
		logic [15:0] clut [clut_pkg::PALETTE_DEPTH];
		rgba_t       owed_pixels [$];
		int          errors;

		function new();
			errors = 0;
			foreach (clut[i])
				clut[i] = 16'd0;
		endfunction

		function rgba_t decode_texel(texel_req_t req);
			logic [8:0]  index;
			logic [15:0] word;
			logic [7:0]  hi;
			logic [15:0] sq;
			rgba_t       px;
			if (req.four)
				index = req.odd ? {5'd0, req.tbyte[7:4]} : {5'd0, req.tbyte[3:0]};
			else
				index = {1'b0, req.tbyte};
			word = (index < clut_pkg::PALETTE_DEPTH) ? clut[index[7:0]] : 16'd0;
			px = '0;
			if (word == 16'd0)
				return px;
			px.red   = {word[4:0], 3'b000};
			px.green = {word[9:5], 3'b000};
			px.blue  = {word[14:10], 3'b000};
			hi = (px.red > px.green) ? px.red : px.green;
			if (px.blue > hi)
				hi = px.blue;
			sq = (16'(hi) * 16'(hi)) >> 8;
			px.alpha = clut_pkg::ALPHA_OPAQUE;
			if (word[15] && req.transp) begin
				case (req.mode)
					clut_pkg::BLEND_HALF:    px.alpha = clut_pkg::ALPHA_HALF;
					clut_pkg::BLEND_FULL:    px.alpha = (sq > 16'd63) ?
						clut_pkg::ALPHA_OPAQUE : 8'(sq * 4);
					clut_pkg::BLEND_INV:     px.alpha = clut_pkg::ALPHA_OPAQUE - hi;
					clut_pkg::BLEND_QUARTER: px.alpha = sq[7:0];
					default:                 px.alpha = clut_pkg::ALPHA_OPAQUE;
				endcase
			end
			return px;
		endfunction

		// Update the palette on a load, queue the expected pixel on a texel.
		function void note_input(texel_req_t req);
			if (req.op == clut_pkg::OP_LOAD) begin
				if (req.slot < clut_pkg::PALETTE_DEPTH)
					clut[req.slot] = req.word;
			end else begin
				owed_pixels = {owed_pixels, decode_texel(req)};
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(rgba_t got);
			rgba_t want;
			if (owed_pixels.size() == 0) begin
				$error("unexpected pixel r=%0d g=%0d b=%0d a=%0d",
					got.red, got.green, got.blue, got.alpha);
				errors++;
				return;
			end
			want = owed_pixels.pop_front();
			compare_field("red", want.red, got.red);
			compare_field("green", want.green, got.green);
			compare_field("blue", want.blue, got.blue);
			compare_field("alpha", want.alpha, got.alpha);
		endfunction

		function int pending();
			return owed_pixels.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [7:0]  palette_slot;
	logic [15:0] palette_word;
	logic [7:0]  texel_byte;
	logic        odd_column;
	logic        four_bit_mode;
	logic        face_transparent;
	logic [1:0]  blend_mode;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;

	rgba_scoreboard sb;
	int             cycle_count;
	int             items_sent;
	bit             calm;             // set for the last stretch: no idling on either side
	bit             long_hold_done;

	// Generator's view of which palette entries hold a defined word.
	bit             slot_written [256];
	int             written_slots [$];
	int             low_slots [$];    // written entries reachable by a 4-bit index

	clut_texel_to_rgba dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.opcode           (opcode),
		.palette_slot     (palette_slot),
		.palette_word     (palette_word),
		.texel_byte       (texel_byte),
		.odd_column       (odd_column),
		.four_bit_mode    (four_bit_mode),
		.face_transparent (face_transparent),
		.blend_mode       (blend_mode),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.alpha            (alpha)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Predict on every accepted item, in acceptance order.
	always @(posedge clk) begin
		texel_req_t req;
		if (arst_n && in_valid && in_ready) begin
			req.op     = opcode;
			req.slot   = palette_slot;
			req.word   = palette_word;
			req.tbyte  = texel_byte;
			req.odd    = odd_column;
			req.four   = four_bit_mode;
			req.transp = face_transparent;
			req.mode   = blend_mode;
			sb.note_input(req);
		end
	end

	// Check every pixel the receiver takes.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{red, green, blue, alpha});
	end

	// Receiver: random stall bursts, quiet stretches, and one long hold so the
	// pipeline fills and in_ready drops while the sender keeps offering.
	initial begin
		int  burst;
		int  stretch;
		bit  stall_on;
		stretch  = 0;
		stall_on = 1'b1;
		forever begin
			@(negedge clk);
			stretch++;
			if (stretch == 64) begin
				stretch  = 0;
				stall_on = ($urandom_range(0, 2) != 0);
			end
			if (calm) begin
				out_ready = 1'b1;
			end else if (!long_hold_done && items_sent >= HOLD_AT) begin
				long_hold_done = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (stall_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 11);
				out_ready = 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Safety net against a hung pipeline.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	// Present one item and hold it until the block takes it.
	task automatic send_item(input texel_req_t req);
		@(negedge clk);
		opcode           = req.op;
		palette_slot     = req.slot;
		palette_word     = req.word;
		texel_byte       = req.tbyte;
		odd_column       = req.odd;
		four_bit_mode    = req.four;
		face_transparent = req.transp;
		blend_mode       = req.mode;
		in_valid         = 1'b1;
		if (req.op == clut_pkg::OP_LOAD && !slot_written[req.slot]) begin
			slot_written[req.slot] = 1'b1;
			written_slots = {written_slots, int'(req.slot)};
			if (req.slot < 16)
				low_slots = {low_slots, int'(req.slot)};
		end
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// Drop valid for a burst of cycles; scramble the payload meanwhile.
	task automatic idle_input(input int cycles);
		@(negedge clk);
		in_valid     = 1'b0;
		texel_byte   = 8'($urandom);
		palette_word = 16'($urandom);
		repeat (cycles - 1) @(negedge clk);
	endtask

	function automatic texel_req_t load_req(logic [7:0] slot, logic [15:0] word);
		texel_req_t req;
		req.op     = clut_pkg::OP_LOAD;
		req.slot   = slot;
		req.word   = word;
		req.tbyte  = 8'($urandom);
		req.odd    = 1'($urandom);
		req.four   = 1'($urandom);
		req.transp = 1'($urandom);
		req.mode   = 2'($urandom);
		return req;
	endfunction

	function automatic texel_req_t texel_req(logic [7:0] tbyte, logic odd, logic four,
			logic transp, logic [1:0] mode);
		texel_req_t req;
		req.op     = clut_pkg::OP_TEXEL;
		req.slot   = 8'($urandom);
		req.word   = 16'($urandom);
		req.tbyte  = tbyte;
		req.odd    = odd;
		req.four   = four;
		req.transp = transp;
		req.mode   = mode;
		return req;
	endfunction

	// Random item: loads biased toward the low sixteen slots, texels only ever
	// pointing at entries already written.
	function automatic texel_req_t random_req();
		logic [15:0] word;
		logic [3:0]  nib;
		logic [3:0]  other;
		logic        odd;
		logic [7:0]  slot;
		if (written_slots.size() == 0 || $urandom_range(0, 99) < 25) begin
			slot = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
			case ($urandom_range(0, 9))
				0:       word = 16'h0000;
				1:       word = 16'hFFFF;
				2:       word = 16'h8000;
				3:       word = {1'b1, 15'($urandom)};
				default: word = 16'($urandom);
			endcase
			return load_req(slot, word);
		end
		if (low_slots.size() != 0 && $urandom_range(0, 1) == 0) begin
			nib   = 4'(low_slots[$urandom_range(0, low_slots.size() - 1)]);
			other = 4'($urandom);
			odd   = 1'($urandom);
			return texel_req(odd ? {nib, other} : {other, nib}, odd, 1'b1,
				1'($urandom), 2'($urandom));
		end
		return texel_req(8'(written_slots[$urandom_range(0, written_slots.size() - 1)]),
			1'($urandom), 1'b0, 1'($urandom), 2'($urandom));
	endfunction

	initial begin
		texel_req_t directed [$];
		int         stretch;
		bit         gaps_on;

		clk              = 1'b0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		opcode           = clut_pkg::OP_LOAD;
		palette_slot     = 8'd0;
		palette_word     = 16'd0;
		texel_byte       = 8'd0;
		odd_column       = 1'b0;
		four_bit_mode    = 1'b0;
		face_transparent = 1'b0;
		blend_mode       = clut_pkg::BLEND_HALF;
		out_ready        = 1'b1;
		cycle_count      = 0;
		items_sent       = 0;
		calm             = 1'b0;
		long_hold_done   = 1'b0;
		sb = new();

		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed: zero word, all-ones word with semi bit, semi bit on black,
		// white without semi bit, both nibbles, every blend mode, opaque face.
		directed = {directed, load_req(8'd0, 16'h0000)};
		directed = {directed, load_req(8'd255, 16'hFFFF)};
		directed = {directed, load_req(8'd1, 16'h8000)};
		directed = {directed, load_req(8'd15, 16'h7FFF)};
		directed = {directed, load_req(8'd5, 16'h801F)};
		directed = {directed, load_req(8'd240, 16'h83E0)};
		directed = {directed, texel_req(8'd255, 1'b0, 1'b0, 1'b1, clut_pkg::BLEND_HALF)};
		directed = {directed, texel_req(8'd255, 1'b0, 1'b0, 1'b1, clut_pkg::BLEND_FULL)};
		directed = {directed, texel_req(8'd255, 1'b1, 1'b0, 1'b1, clut_pkg::BLEND_INV)};
		directed = {directed, texel_req(8'd255, 1'b0, 1'b0, 1'b1, clut_pkg::BLEND_QUARTER)};
		directed = {directed, texel_req(8'd255, 1'b0, 1'b0, 1'b0, clut_pkg::BLEND_FULL)};
		directed = {directed, texel_req(8'd0, 1'b0, 1'b0, 1'b1, clut_pkg::BLEND_INV)};
		directed = {directed, texel_req(8'hF1, 1'b0, 1'b1, 1'b1, clut_pkg::BLEND_INV)};
		directed = {directed, texel_req(8'hF1, 1'b0, 1'b1, 1'b1, clut_pkg::BLEND_FULL)};
		directed = {directed, texel_req(8'hF1, 1'b1, 1'b1, 1'b1, clut_pkg::BLEND_HALF)};
		directed = {directed, texel_req(8'h05, 1'b0, 1'b1, 1'b1, clut_pkg::BLEND_FULL)};
		directed = {directed, texel_req(8'h5A, 1'b1, 1'b1, 1'b1, clut_pkg::BLEND_QUARTER)};
		directed = {directed, texel_req(8'd240, 1'b1, 1'b0, 1'b1, clut_pkg::BLEND_HALF)};
		directed = {directed, texel_req(8'h0F, 1'b1, 1'b0, 1'b1, clut_pkg::BLEND_QUARTER)};
		directed = {directed, texel_req(8'h10, 1'b0, 1'b1, 1'b1, clut_pkg::BLEND_HALF)};
		foreach (directed[i])
			send_item(directed[i]);

		// Random part: sender gaps come and go in stretches of 64 items.
		stretch = 0;
		gaps_on = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			if (++stretch == 64) begin
				stretch = 0;
				gaps_on = ($urandom_range(0, 2) != 0);
			end
			if (!calm && gaps_on && $urandom_range(0, 4) == 0)
				idle_input($urandom_range(1, 11));
			send_item(random_req());
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* clut_texel_to_rgba.f */
rtl/clut_pkg.sv
rtl/clut_palette.sv
rtl/clut_unpack.sv
rtl/clut_alpha.sv
rtl/clut_texel_to_rgba.sv
rtl/clut_checker.sv
verif/tb_clut_texel_to_rgba.sv
